// ===== rtl/core/vgnl_pkg.sv =====
// Package with the constants, codes and decode tables of the voxel grid lookup.
`timescale 1ns / 1ps
package vgnl_pkg;

   localparam int VOXEL_DEPTH     = 65536;
   localparam int ADDR_W          = $clog2(VOXEL_DEPTH);
   localparam int COORD_W         = 24;
   localparam int COORD_FRAC_BITS = 8;
   localparam int INT_W           = COORD_W - COORD_FRAC_BITS;
   localparam int TABLE_ENTRIES   = 256;
   localparam int RES_W           = 11;
   localparam int COMP_W          = 18;
   localparam int CSR_INDEX_W     = 8;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   localparam logic [1:0] KIND_FLOAT = 2'd0;
   localparam logic [1:0] KIND_U8    = 2'd1;
   localparam logic [1:0] KIND_RGB   = 2'd2;
   localparam logic [1:0] KIND_DIR   = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_RES_X = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RES_Y = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RES_Z = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KIND  = 8'd3;

   localparam int TAB_DENS = 0;
   localparam int TAB_COST = 1;
   localparam int TAB_SINT = 2;
   localparam int TAB_COSP = 3;
   localparam int TAB_SINP = 4;

   localparam longint unsigned PI_Q60   = 64'h3243F6A8885A308D;
   localparam longint unsigned PI_STEP  = PI_Q60 / 510;
   localparam longint unsigned ONE_Q30  = 64'd1 << 30;

   typedef logic signed [COMP_W-1:0] tab_type [TABLE_ENTRIES];

   function automatic int q30_to_q16(input longint unsigned v);
      return int'((v + 64'd8192) >> 14);
   endfunction

   // Sine and cosine of n * pi / 510 in Q1.16, packed as {sine, cosine}.
   function automatic logic [63:0] sincos_units(input int unsigned n);
      int unsigned q;
      int r;
      longint unsigned mag, x, x2, t, s, c;
      int sr, cr, so, co;
      q = (2 * n + 255) / 510;
      r = int'(n) - int'(255 * q);
      mag = (r < 0) ? longint'(-r) : longint'(r);
      x = (mag * PI_STEP) >> 30;
      x2 = (x * x) >> 30;
      t = x;
      s = x;
      t = ((t * x2) >> 30) / 6;   s = s - t;
      t = ((t * x2) >> 30) / 20;  s = s + t;
      t = ((t * x2) >> 30) / 42;  s = s - t;
      t = ((t * x2) >> 30) / 72;  s = s + t;
      t = ((t * x2) >> 30) / 110; s = s - t;
      t = ((t * x2) >> 30) / 156; s = s + t;
      t = ((t * x2) >> 30) / 210; s = s - t;
      t = ONE_Q30;
      c = ONE_Q30;
      t = ((t * x2) >> 30) / 2;   c = c - t;
      t = ((t * x2) >> 30) / 12;  c = c + t;
      t = ((t * x2) >> 30) / 30;  c = c - t;
      t = ((t * x2) >> 30) / 56;  c = c + t;
      t = ((t * x2) >> 30) / 90;  c = c - t;
      t = ((t * x2) >> 30) / 132; c = c + t;
      t = ((t * x2) >> 30) / 182; c = c - t;
      sr = q30_to_q16(s);
      if (r < 0) sr = -sr;
      cr = q30_to_q16(c);
      case (q & 3)
         0:       begin so = sr;  co = cr;  end
         1:       begin so = cr;  co = -sr; end
         2:       begin so = -sr; co = -cr; end
         default: begin so = -cr; co = sr;  end
      endcase
      return {so, co};
   endfunction

   function automatic tab_type build_tab(input int which);
      tab_type tb;
      logic [63:0] sc;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (which == TAB_DENS) begin
            tb[i] = COMP_W'((i * 65536 + 127) / 255);
         end else if (i == TABLE_ENTRIES - 1) begin
            tb[i] = '0;
         end else begin
            sc = (which == TAB_COST || which == TAB_SINT) ? sincos_units(2 * i)
                                                          : sincos_units(4 * i);
            tb[i] = (which == TAB_SINT || which == TAB_SINP) ? sc[COMP_W+31:32]
                                                             : sc[COMP_W-1:0];
         end
      end
      return tb;
   endfunction

   localparam tab_type DENS_TAB = build_tab(TAB_DENS);
   localparam tab_type COST_TAB = build_tab(TAB_COST);
   localparam tab_type SINT_TAB = build_tab(TAB_SINT);
   localparam tab_type COSP_TAB = build_tab(TAB_COSP);
   localparam tab_type SINP_TAB = build_tab(TAB_SINP);

endpackage

// ===== rtl/core/vgnl_if.sv =====
// Channel interfaces of the voxel grid lookup: request, response and register write.
`timescale 1ns / 1ps
interface vgnl_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [23:0] grid_x;
   logic signed [23:0] grid_y;
   logic signed [23:0] grid_z;
   logic [15:0]        write_address;
   logic [31:0]        write_word;
   modport source (output valid, action, grid_x, grid_y, grid_z, write_address,
                   write_word, input ready);
   modport sink (input valid, action, grid_x, grid_y, grid_z, write_address,
                 write_word, output ready);
endinterface

interface vgnl_rsp_if;
   logic               valid;
   logic               ready;
   logic               in_range;
   logic [15:0]        voxel_index;
   logic [31:0]        scalar_value;
   logic signed [17:0] comp_a;
   logic signed [17:0] comp_b;
   logic signed [17:0] comp_c;
   modport source (output valid, in_range, voxel_index, scalar_value, comp_a, comp_b,
                   comp_c, input ready);
   modport sink (input valid, in_range, voxel_index, scalar_value, comp_a, comp_b,
                 comp_c, output ready);
endinterface

interface vgnl_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [10:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/voxel_grid_nearest_lookup.sv =====
// Top level of the voxel grid nearest-neighbour lookup.
//
// A request transaction either writes a 32-bit voxel word into the voxel store
// (action 0) or looks up a fixed-point grid point (action 1). Writes give no
// response; every lookup gives exactly one response transaction, in order.
// The csr channel sets res_x, res_y, res_z and volume_kind; the user must write
// it only while the block is idle, which the block does not enforce. The channel is always ready.
// One transaction is taken each cycle while the receiver does not stall.
// The pipeline runs the wrap of x and y as four stages of a restoring
// remainder (four bits each), two registered index multiplies, one read of the
// single-port voxel memory and a registered decode with one multiplier stage.
// Items pass the memory in order, so a write is seen by every later lookup.
// When the receiver stalls the output register holds its response and the
// whole pipeline, and so req ready, stops until it is taken.
// Reset empties the pipeline and sets the registers to 1, 1, 2 and 0; the
// voxel store is not cleared and must be written before it is read.
`timescale 1ns / 1ps
module voxel_grid_nearest_lookup (
   input logic clock,
   input logic reset,
   vgnl_req_if.sink   req_if,
   vgnl_rsp_if.source rsp_if,
   vgnl_csr_if.sink   csr_if
);
   import vgnl_pkg::*;

   localparam int MOD_STEPS  = 4;
   localparam int MOD_STAGES = INT_W / MOD_STEPS;
   localparam int ST_WRAP    = MOD_STAGES + 1;
   localparam int ST_ROW     = MOD_STAGES + 2;
   localparam int ST_IDX     = MOD_STAGES + 3;
   localparam int ST_MEM     = MOD_STAGES + 4;
   localparam int PROD_W     = 2 * COMP_W;

   typedef struct packed {
      logic               vld;
      logic               act;
      logic               bad;
      logic [INT_W-1:0]   mx;
      logic [INT_W-1:0]   my;
      logic               negx;
      logic               negy;
      logic               upx;
      logic               upy;
      logic [RES_W-1:0]   rx;
      logic [RES_W-1:0]   ry;
      logic [RES_W-1:0]   iz;
      logic [31:0]        idx;
      logic [ADDR_W-1:0]  addr;
      logic [31:0]        word;
   } pipe_type;

   typedef struct packed {
      logic                     vld;
      logic                     bad;
      logic [1:0]               kind;
      logic [ADDR_W-1:0]        idx;
      logic [31:0]              scalar;
      logic signed [COMP_W-1:0] ca;
      logic signed [COMP_W-1:0] cb;
      logic signed [COMP_W-1:0] cc;
      logic signed [PROD_W-1:0] pa;
      logic signed [PROD_W-1:0] pb;
   } dec_type;

   logic [RES_W-1:0] res_x_ff, res_y_ff, res_z_ff;
   logic [1:0]       kind_ff;

   pipe_type st_ff [ST_MEM+1];
   pipe_type st_in [ST_MEM+1];
   logic [31:0] rdata_ff;
   logic [31:0] voxel_mem [VOXEL_DEPTH];
   dec_type dec_ff, dec_in;

   logic                     rsp_vld_ff;
   logic                     in_range_ff;
   logic [ADDR_W-1:0]        index_ff;
   logic [31:0]              scalar_ff;
   logic signed [COMP_W-1:0] ca_ff, cb_ff, cc_ff;
   logic                     in_range_in;
   logic [31:0]              scalar_in;
   logic signed [COMP_W-1:0] ca_in, cb_in, cc_in;

   logic adv;

   assign adv = !rsp_vld_ff || rsp_if.ready;
   assign req_if.ready = adv;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_x_ff <= RES_W'(1);
         res_y_ff <= RES_W'(1);
         res_z_ff <= RES_W'(2);
         kind_ff  <= KIND_FLOAT;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_RES_X: res_x_ff <= csr_if.data;
            REG_RES_Y: res_y_ff <= csr_if.data;
            REG_RES_Z: res_z_ff <= csr_if.data;
            REG_KIND:  kind_ff  <= csr_if.data[1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [RES_W-1:0] mod_step(input logic [RES_W-1:0] r,
                                                 input logic b,
                                                 input logic [RES_W-1:0] res);
      logic [RES_W:0] t;
      t = {r, b};
      if (t >= {1'b0, res}) t = t - {1'b0, res};
      return t[RES_W-1:0];
   endfunction

   function automatic logic [RES_W-1:0] wrap_fix(input logic [RES_W-1:0] r,
                                                 input logic neg, input logic up,
                                                 input logic [RES_W-1:0] res);
      logic [RES_W-1:0] a;
      a = (neg && r != '0) ? res - r : r;
      if (up) a = (a + RES_W'(1) == res) ? '0 : a + RES_W'(1);
      return a;
   endfunction

   always_comb begin
      logic signed [INT_W-1:0] fx, fy, fz;
      logic [INT_W:0]          zn;
      fx = req_if.grid_x[COORD_W-1:COORD_FRAC_BITS];
      fy = req_if.grid_y[COORD_W-1:COORD_FRAC_BITS];
      fz = req_if.grid_z[COORD_W-1:COORD_FRAC_BITS];
      zn = {1'b0, fz} + (INT_W+1)'(1);
      st_in[0] = '0;
      st_in[0].vld  = req_if.valid;
      st_in[0].act  = req_if.action;
      st_in[0].negx = fx[INT_W-1];
      st_in[0].negy = fy[INT_W-1];
      st_in[0].mx   = fx[INT_W-1] ? INT_W'(-fx) : INT_W'(fx);
      st_in[0].my   = fy[INT_W-1] ? INT_W'(-fy) : INT_W'(fy);
      st_in[0].upx  = req_if.grid_x[COORD_FRAC_BITS-1];
      st_in[0].upy  = req_if.grid_y[COORD_FRAC_BITS-1];
      // The z bound is checked on the floor; the rounded index is one higher at most.
      st_in[0].bad  = (res_x_ff == '0) || (res_y_ff == '0) || fz[INT_W-1] ||
                      (zn >= (INT_W+1)'(res_z_ff));
      st_in[0].iz   = RES_W'(fz) + RES_W'(req_if.grid_z[COORD_FRAC_BITS-1]);
      st_in[0].addr = req_if.write_address;
      st_in[0].word = req_if.write_word;

      for (int s = 1; s <= MOD_STAGES; s++) begin
         st_in[s] = st_ff[s-1];
         for (int k = 0; k < MOD_STEPS; k++) begin
            st_in[s].rx = mod_step(st_in[s].rx, st_in[s].mx[INT_W-1], res_x_ff);
            st_in[s].ry = mod_step(st_in[s].ry, st_in[s].my[INT_W-1], res_y_ff);
            st_in[s].mx = st_in[s].mx << 1;
            st_in[s].my = st_in[s].my << 1;
         end
      end

      st_in[ST_WRAP] = st_ff[ST_WRAP-1];
      st_in[ST_WRAP].rx = wrap_fix(st_ff[ST_WRAP-1].rx, st_ff[ST_WRAP-1].negx,
                                   st_ff[ST_WRAP-1].upx, res_x_ff);
      st_in[ST_WRAP].ry = wrap_fix(st_ff[ST_WRAP-1].ry, st_ff[ST_WRAP-1].negy,
                                   st_ff[ST_WRAP-1].upy, res_y_ff);

      st_in[ST_ROW] = st_ff[ST_ROW-1];
      st_in[ST_ROW].idx = 32'(st_ff[ST_ROW-1].iz) * 32'(res_y_ff)
                        + 32'(st_ff[ST_ROW-1].ry);

      // A row beyond the store already puts the index beyond it, and keeps the
      // product below 32 bits when it does not.
      st_in[ST_IDX] = st_ff[ST_IDX-1];
      st_in[ST_IDX].idx = 32'(st_ff[ST_IDX-1].idx[2*RES_W-1:0]) * 32'(res_x_ff)
                        + 32'(st_ff[ST_IDX-1].rx);
      st_in[ST_IDX].bad = st_ff[ST_IDX-1].bad || (st_ff[ST_IDX-1].idx[31:ADDR_W] != '0) ||
                          (st_in[ST_IDX].idx[31:ADDR_W] != '0);

      st_in[ST_MEM] = st_ff[ST_MEM-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= ST_MEM; s++) begin
            st_ff[s].vld <= 1'b0;
         end
      end else if (adv) begin
         for (int s = 0; s <= ST_MEM; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // Single-port voxel store: the item leaving the index stage writes or reads it.
   always_ff @(posedge clock) begin
      if (adv && st_ff[ST_IDX].vld) begin
         if (st_ff[ST_IDX].act == ACT_WRITE) begin
            voxel_mem[st_ff[ST_IDX].addr] <= st_ff[ST_IDX].word;
         end else begin
            rdata_ff <= voxel_mem[st_ff[ST_IDX].idx[ADDR_W-1:0]];
         end
      end
   end

   always_comb begin
      logic [7:0] b0, b1, b2;
      b0 = rdata_ff[7:0];
      b1 = rdata_ff[15:8];
      b2 = rdata_ff[23:16];
      dec_in = '0;
      dec_in.vld  = st_ff[ST_MEM].vld && (st_ff[ST_MEM].act == ACT_LOOKUP);
      dec_in.bad  = st_ff[ST_MEM].bad;
      dec_in.kind = kind_ff;
      dec_in.idx  = st_ff[ST_MEM].idx[ADDR_W-1:0];
      case (kind_ff)
         KIND_FLOAT: dec_in.scalar = rdata_ff;
         KIND_U8:    dec_in.scalar = 32'(DENS_TAB[b0]);
         KIND_RGB: begin
            dec_in.ca = DENS_TAB[b0];
            dec_in.cb = DENS_TAB[b1];
            dec_in.cc = DENS_TAB[b2];
         end
         default: begin
            dec_in.pa = PROD_W'(COSP_TAB[b1]) * PROD_W'(SINT_TAB[b0]);
            dec_in.pb = PROD_W'(SINP_TAB[b1]) * PROD_W'(SINT_TAB[b0]);
            dec_in.cc = COST_TAB[b0];
         end
      endcase
   end

   function automatic logic signed [COMP_W-1:0] round_q16(
      input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] m;
      logic [PROD_W-1:0] r;
      m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      r = (m + PROD_W'(32768)) >> 16;
      return p[PROD_W-1] ? COMP_W'(-r) : COMP_W'(r);
   endfunction

   always_comb begin
      in_range_in = !dec_ff.bad;
      scalar_in   = '0;
      ca_in       = '0;
      cb_in       = '0;
      cc_in       = '0;
      if (!dec_ff.bad) begin
         scalar_in = dec_ff.scalar;
         cc_in     = dec_ff.cc;
         if (dec_ff.kind == KIND_DIR) begin
            ca_in = round_q16(dec_ff.pa);
            cb_in = round_q16(dec_ff.pb);
         end else begin
            ca_in = dec_ff.ca;
            cb_in = dec_ff.cb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.vld <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         dec_ff      <= dec_in;
         in_range_ff <= in_range_in;
         index_ff    <= dec_ff.bad ? '0 : dec_ff.idx;
         scalar_ff   <= scalar_in;
         ca_ff       <= ca_in;
         cb_ff       <= cb_in;
         cc_ff       <= cc_in;
         rsp_vld_ff  <= dec_ff.vld;
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.in_range     = in_range_ff;
   assign rsp_if.voxel_index  = index_ff;
   assign rsp_if.scalar_value = scalar_ff;
   assign rsp_if.comp_a       = ca_ff;
   assign rsp_if.comp_b       = cb_ff;
   assign rsp_if.comp_c       = cc_ff;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the voxel grid nearest-neighbour lookup.
`timescale 1ns / 1ps
module tb_top;
   import vgnl_pkg::*;

   typedef struct {
      logic               in_range;
      logic [15:0]        voxel_index;
      logic [31:0]        scalar_value;
      logic signed [17:0] comp_a;
      logic signed [17:0] comp_b;
      logic signed [17:0] comp_c;
   } lookup_result;

   typedef struct {
      logic               action;
      logic signed [23:0] gx;
      logic signed [23:0] gy;
      logic signed [23:0] gz;
      logic [15:0]        address;
      logic [31:0]        word;
      bit                 typed;
      lookup_result       known;
   } stim_row;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam lookup_result NO_VOXEL = '{1'b0, '0, '0, '0, '0, '0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   vgnl_req_if req ();
   vgnl_rsp_if rsp ();
   vgnl_csr_if csr ();

   voxel_grid_nearest_lookup i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   always #1 clock = ~clock;

   // Model state of the block.
   logic [31:0] voxel_model [VOXEL_DEPTH];
   bit          voxel_written [VOXEL_DEPTH];
   int          dens_q16 [TABLE_ENTRIES];
   int          cos_theta [TABLE_ENTRIES];
   int          sin_theta [TABLE_ENTRIES];
   int          cos_phi [TABLE_ENTRIES];
   int          sin_phi [TABLE_ENTRIES];
   int unsigned res_x, res_y, res_z;
   logic [1:0]  volume_kind;

   lookup_result pending_lookups [$];
   stim_row      directed_rows [$];
   int          errors = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;
   int          idle_cycles = 0;

   function automatic void add_row(input stim_row row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void expect_lookup(input lookup_result r);
      pending_lookups.insert(pending_lookups.size(), r);
   endfunction

   // Sine and cosine of n * pi / 510 by a Q30 Taylor series, rounded to Q1.16.
   function automatic void trig_units(input int unsigned n, output int sv, output int cv);
      int unsigned     quad;
      int              rem, sr, cr;
      longint unsigned mag, x, x2, t, s, c;
      quad = (2 * n + 255) / 510;
      rem = int'(n) - int'(255 * quad);
      mag = (rem < 0) ? longint'(-rem) : longint'(rem);
      x = (mag * (64'h3243F6A8885A308D / 510)) >> 30;
      x2 = (x * x) >> 30;
      t = x;
      s = x;
      for (int i = 1; i <= 7; i++) begin
         t = ((t * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
         if (i % 2 == 1) s = s - t; else s = s + t;
      end
      t = 64'd1 << 30;
      c = t;
      for (int i = 1; i <= 7; i++) begin
         t = ((t * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
         if (i % 2 == 1) c = c - t; else c = c + t;
      end
      sr = int'((s + 64'd8192) >> 14);
      if (rem < 0) sr = -sr;
      cr = int'((c + 64'd8192) >> 14);
      case (quad % 4)
         0: begin sv = sr; cv = cr; end
         1: begin sv = cr; cv = -sr; end
         2: begin sv = -sr; cv = -cr; end
         default: begin sv = -cr; cv = sr; end
      endcase
   endfunction

   function automatic int mul_q16(input int a, input int b);
      longint          p;
      longint unsigned m;
      int              r;
      p = longint'(a) * longint'(b);
      m = (p < 0) ? -p : p;
      r = int'((m + 32768) >> 16);
      return (p < 0) ? -r : r;
   endfunction

   function automatic longint unsigned wrap_axis(input longint v, input int unsigned res,
                                                 input bit up);
      longint a;
      a = v % longint'(res);
      if (a < 0) a += res;
      if (up) a = (a + 1) % longint'(res);
      return a;
   endfunction

   // Linear voxel index a lookup reads, or -1 when it gets the empty result.
   function automatic longint voxel_of(input logic signed [23:0] gx,
                                       input logic signed [23:0] gy,
                                       input logic signed [23:0] gz);
      longint z_floor, idx;
      z_floor = longint'(gz) >>> COORD_FRAC_BITS;
      if (res_x == 0 || res_y == 0 || z_floor < 0 || z_floor + 1 >= longint'(res_z))
         return -1;
      idx = ((z_floor + gz[7]) * res_y
             + wrap_axis(longint'(gy) >>> COORD_FRAC_BITS, res_y, gy[7])) * res_x
            + wrap_axis(longint'(gx) >>> COORD_FRAC_BITS, res_x, gx[7]);
      return (idx >= VOXEL_DEPTH) ? -1 : idx;
   endfunction

   function automatic lookup_result predict_lookup(input logic signed [23:0] gx,
                                                   input logic signed [23:0] gy,
                                                   input logic signed [23:0] gz);
      lookup_result r;
      longint       idx;
      logic [31:0]  w;
      r = NO_VOXEL;
      idx = voxel_of(gx, gy, gz);
      if (idx < 0) return r;
      w = voxel_model[idx];
      r.in_range = 1'b1;
      r.voxel_index = idx[15:0];
      case (volume_kind)
         KIND_FLOAT: r.scalar_value = w;
         KIND_U8: r.scalar_value = 32'(dens_q16[w[7:0]]);
         KIND_RGB: begin
            r.comp_a = 18'(dens_q16[w[7:0]]);
            r.comp_b = 18'(dens_q16[w[15:8]]);
            r.comp_c = 18'(dens_q16[w[23:16]]);
         end
         default: begin
            r.comp_a = 18'(mul_q16(cos_phi[w[15:8]], sin_theta[w[7:0]]));
            r.comp_b = 18'(mul_q16(sin_phi[w[15:8]], sin_theta[w[7:0]]));
            r.comp_c = 18'(cos_theta[w[7:0]]);
         end
      endcase
      return r;
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      // Push the decode bytes onto their table ends now and then.
      for (int b = 0; b < 3; b++)
         if ($urandom_range(0, 5) == 0) w[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return w;
   endfunction

   function automatic logic signed [23:0] near_coord(input int unsigned res);
      int span;
      if (res == 0 || $urandom_range(0, 9) == 0) return 24'($urandom);
      span = res * 512;
      return 24'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic send_item(input stim_row row);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req.valid <= 1'b1;
      req.action <= row.action;
      req.grid_x <= row.gx;
      req.grid_y <= row.gy;
      req.grid_z <= row.gz;
      req.write_address <= row.address;
      req.write_word <= row.word;
      do @(posedge clock); while (!req.ready);
      burst_left--;
      if (row.action == ACT_WRITE) begin
         voxel_model[row.address] = row.word;
         voxel_written[row.address] = 1'b1;
      end else begin
         expect_lookup(row.typed ? row.known : predict_lookup(row.gx, row.gy, row.gz));
      end
   endtask

   task automatic write_voxel(input logic [15:0] address, input logic [31:0] word);
      stim_row row;
      row = '{ACT_WRITE, 24'($urandom), 24'($urandom), 24'($urandom), address, word, 1'b0,
              NO_VOXEL};
      send_item(row);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data <= value[10:0];
      do @(posedge clock); while (!csr.ready);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      burst_left = 0;
      while (pending_lookups.size() != 0) @(posedge clock);
      // Writes give no response and may still be in the pipeline.
      repeat (16) @(posedge clock);
   endtask

   task automatic configure(input int unsigned rx, input int unsigned ry,
                            input int unsigned rz, input logic [1:0] kind);
      wait_idle();
      write_register(REG_RES_X, rx);
      write_register(REG_RES_Y, ry);
      write_register(REG_RES_Z, rz);
      write_register(REG_KIND, 32'(kind));
      csr.valid <= 1'b0;
      res_x = rx;
      res_y = ry;
      res_z = rz;
      volume_kind = kind;
   endtask

   task automatic random_phase(input int count);
      stim_row row;
      longint  idx;
      for (int n = 0; n < count; n++) begin
         row = '{ACT_LOOKUP, '0, '0, '0, 16'($urandom), $urandom, 1'b0, NO_VOXEL};
         if ($urandom_range(0, 4) == 0) begin
            row.action = ACT_WRITE;
            row.gx = 24'($urandom);
            row.gy = 24'($urandom);
            row.gz = 24'($urandom);
            row.word = random_word();
         end else if ($urandom_range(0, 7) == 0) begin
            row.gx = 24'($urandom);
            row.gy = 24'($urandom);
            row.gz = 24'($urandom);
         end else begin
            row.gx = near_coord(res_x);
            row.gy = near_coord(res_y);
            if (res_z >= 2 && $urandom_range(0, 4) != 0)
               row.gz = 24'($urandom_range(0, (res_z - 1) * 256 - 1));
            else
               row.gz = near_coord(res_z);
         end
         if (row.action == ACT_LOOKUP) begin
            idx = voxel_of(row.gx, row.gy, row.gz);
            // A voxel is always written before it is first read.
            if (idx >= 0 && !voxel_written[idx]) write_voxel(idx[15:0], random_word());
         end
         send_item(row);
      end
   endtask

   // Receiver: runs of always ready, random stalls and long stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      lookup_result want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_lookups.size() == 0) begin
            $error("response transaction with no lookup outstanding");
            errors++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp.in_range !== want.in_range) begin
               $error("in_range: expected %0d, got %0d", want.in_range, rsp.in_range);
               errors++;
            end
            if (rsp.voxel_index !== want.voxel_index) begin
               $error("voxel_index: expected %0d, got %0d", want.voxel_index, rsp.voxel_index);
               errors++;
            end
            if (rsp.scalar_value !== want.scalar_value) begin
               $error("scalar_value: expected %h, got %h", want.scalar_value, rsp.scalar_value);
               errors++;
            end
            if (rsp.comp_a !== want.comp_a) begin
               $error("comp_a: expected %0d, got %0d", want.comp_a, rsp.comp_a);
               errors++;
            end
            if (rsp.comp_b !== want.comp_b) begin
               $error("comp_b: expected %0d, got %0d", want.comp_b, rsp.comp_b);
               errors++;
            end
            if (rsp.comp_c !== want.comp_c) begin
               $error("comp_c: expected %0d, got %0d", want.comp_c, rsp.comp_c);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int      sv, cv;
      req.valid <= 1'b0;
      req.action <= ACT_WRITE;
      req.grid_x <= '0;
      req.grid_y <= '0;
      req.grid_z <= '0;
      req.write_address <= '0;
      req.write_word <= '0;
      csr.valid <= 1'b0;
      csr.index <= '0;
      csr.data <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         dens_q16[i] = (i * 65536 + 127) / 255;
         if (i < TABLE_ENTRIES - 1) begin
            trig_units(2 * i, sv, cv);
            sin_theta[i] = sv;
            cos_theta[i] = cv;
            trig_units(4 * i, sv, cv);
            sin_phi[i] = sv;
            cos_phi[i] = cv;
         end else begin
            sin_theta[i] = 0;
            cos_theta[i] = 0;
            sin_phi[i] = 0;
            cos_phi[i] = 0;
         end
      end
      res_x = 1;
      res_y = 1;
      res_z = 2;
      volume_kind = KIND_FLOAT;

      // Reset defaults: a 1 x 1 x 2 grid of float words.
      add_row('{ACT_WRITE, 0, 0, 0, 16'h0000, 32'h3F80_0000, 1'b0, NO_VOXEL});
      add_row('{ACT_LOOKUP, 0, 0, 0, 0, 0, 1'b1,
                '{1'b1, 16'd0, 32'h3F80_0000, 0, 0, 0}});
      add_row('{ACT_WRITE, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h0001,
                32'hFFFF_FFFF, 1'b0, NO_VOXEL});
      add_row('{ACT_LOOKUP, 24'h7FFFFF, 24'h800000, 24'h000080, 16'hFFFF,
                32'hFFFF_FFFF, 1'b1, '{1'b1, 16'd1, 32'hFFFF_FFFF, 0, 0, 0}});
      add_row('{ACT_LOOKUP, 0, 0, 24'hFFFFFF, 0, 0, 1'b1, NO_VOXEL});
      add_row('{ACT_LOOKUP, 0, 0, 24'h000100, 0, 0, 1'b1, NO_VOXEL});
      add_row('{ACT_LOOKUP, 0, 0, 24'h7FFFFF, 0, 0, 1'b1, NO_VOXEL});
      add_row('{ACT_LOOKUP, 0, 0, 24'h800000, 0, 0, 1'b1, NO_VOXEL});
      add_row('{ACT_WRITE, 0, 0, 0, 16'hFFFF, 32'h0000_0000, 1'b0, NO_VOXEL});
      add_row('{ACT_WRITE, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0000,
                32'h0000_0000, 1'b0, NO_VOXEL});
      add_row('{ACT_LOOKUP, 24'h00007F, 24'h000080, 24'h00007F, 0, 0, 1'b0,
                NO_VOXEL});
      add_row('{ACT_LOOKUP, 24'h800000, 24'h80007F, 24'h0000FF, 0, 0, 1'b0,
                NO_VOXEL});
      add_row('{ACT_LOOKUP, 24'hFFFF80, 24'hFFFFFF, 24'h000000, 0, 0, 1'b0,
                NO_VOXEL});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[k]) send_item(directed_rows[k]);

      configure(5, 3, 4, KIND_U8);
      random_phase(90);
      configure(1024, 1024, 1024, KIND_DIR);
      random_phase(90);
      configure(16, 8, 6, KIND_RGB);
      random_phase(90);
      configure(0, 4, 4, KIND_FLOAT);
      random_phase(30);
      configure(2047, 2047, 2047, KIND_DIR);
      random_phase(60);
      configure(1, 1, 2, KIND_DIR);
      random_phase(90);
      configure(64, 32, 33, KIND_RGB);
      random_phase(90);
      configure(3, 0, 0, KIND_U8);
      random_phase(30);
      configure(7, 9, 1024, KIND_DIR);
      random_phase(90);
      configure(4, 4, 1, KIND_FLOAT);
      random_phase(30);
      configure(11, 13, 17, KIND_FLOAT);
      random_phase(90);

      wait_idle();
      repeat (24) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
